### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files of the view-matrix block
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LAV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LAV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lav_pkg.sv
// shared types and constants of the view-matrix block
// no dependencies; imported by every module of the block
package lav_pkg;

  localparam int COORD_W = 16;  // input coordinate width, signed q8.8
  localparam int OUT_W   = 32;  // result entry width, signed q16.16
  localparam int NORM_W  = 18;  // normalized component, signed q2.16, |x| <= 1.0
  localparam int ENT_W   = 20;  // rotation entry inside the datapath

  // row codes on the result channel
  localparam logic [1:0] ROW_U    = 2'd0;
  localparam logic [1:0] ROW_V    = 2'd1;
  localparam logic [1:0] ROW_N    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // 1.0 in q16.16, clipped to the result width
  localparam logic [OUT_W-1:0] ONE_OUT =
    (OUT_W > 17) ? OUT_W'(65536) : {1'b0, {(OUT_W-1){1'b1}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] upward_x;
    logic signed [COORD_W-1:0] upward_y;
    logic signed [COORD_W-1:0] upward_z;
  } cam_in_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [OUT_W-1:0] col0;
    logic signed [OUT_W-1:0] col1;
    logic signed [OUT_W-1:0] col2;
    logic signed [OUT_W-1:0] col3;
    logic                    degenerate;
    logic                    last_row;
  } row_out_t;

  // finished 3x4 upper part of the matrix, saturated
  typedef struct packed {
    logic                             degenerate;
    logic [2:0][3:0][OUT_W-1:0]       ent;
  } mat_t;

endpackage

### rtl/core/lav_norm.sv
// pipelined vector normalizer: scale, sum of squares, square root, three dividers
// depends on lav_pkg; output components are signed q2.16 of NORM_W bits
module lav_norm import lav_pkg::*; #(
  parameter int IW = 17,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [2:0][IW-1:0]     in_vec,
  input  logic [SW-1:0]          in_side,
  output logic                   out_vld,
  output logic [2:0][NORM_W-1:0] out_vec,
  output logic                   out_zero,
  output logic [SW-1:0]          out_side
);

  localparam int M_W    = 24;
  localparam int SQS_W  = 2 * M_W;
  localparam int SUM_W  = SQS_W + 2;
  localparam int RAD_W  = 62;
  localparam int FRAC_SH = RAD_W - SUM_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int Q_W    = 17;
  localparam int DR_W   = 32;
  localparam int SQ_N   = ROOT_W;
  localparam int DV_N   = Q_W;
  localparam int LW     = $clog2(IW);
  localparam int WW     = (IW > M_W) ? IW : M_W;
  localparam int SHW    = $clog2(WW) + 1;

  typedef struct packed {
    logic [2:0]    neg;
    logic          zero;
    logic [SW-1:0] side;
  } tag_t;

  // stage 1: magnitudes
  logic                s1_vld;
  logic [2:0][IW-1:0]  s1_mag;
  tag_t                s1_tag;
  logic [2:0][IW-1:0]  abs_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = in_vec[i][IW-1] ? (~in_vec[i] + IW'(1)) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag <= abs_v;
      s1_tag <= '{neg: {in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]},
                  zero: 1'b0, side: in_side};
    end
  end

  // stage 2: leading one of the largest magnitude
  logic               s2_vld;
  logic [2:0][IW-1:0] s2_mag;
  logic [LW-1:0]      s2_msb;
  tag_t               s2_tag;
  logic [IW-1:0]      orv;
  logic [LW-1:0]      msb;

  always_comb begin
    orv = s1_mag[0] | s1_mag[1] | s1_mag[2];
    msb = '0;
    for (int b = 0; b < IW; b++) begin
      if (orv[b]) msb = LW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag <= s1_mag;
      s2_msb <= msb;
      s2_tag <= '{neg: s1_tag.neg, zero: (orv == '0), side: s1_tag.side};
    end
  end

  // stage 3: bring the largest magnitude into [2^23, 2^24)
  logic                s3_vld;
  logic [2:0][M_W-1:0] s3_m;
  tag_t                s3_tag;
  logic [2:0][M_W-1:0] m_sc;
  logic [SHW-1:0]      msb_x;
  logic [WW-1:0]       wide;
  logic [WW-1:0]       shd;

  always_comb begin
    msb_x = SHW'(s2_msb);
    wide  = '0;
    shd   = '0;
    for (int i = 0; i < 3; i++) begin
      wide = WW'(s2_mag[i]);
      if (msb_x > SHW'(M_W - 1)) shd = wide >> (msb_x - SHW'(M_W - 1));
      else shd = wide << (SHW'(M_W - 1) - msb_x);
      m_sc[i] = shd[M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_m   <= m_sc;
      s3_tag <= s2_tag;
    end
  end

  // stage 4: squares
  logic                  s4_vld;
  logic [2:0][SQS_W-1:0] s4_sq;
  logic [2:0][M_W-1:0]   s4_m;
  tag_t                  s4_tag;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_m[i] * s3_m[i];
      s4_m   <= s3_m;
      s4_tag <= s3_tag;
    end
  end

  // stage 5: sum of squares, scaled radicand
  logic                sq_vld  [SQ_N+1];
  logic [RAD_W-1:0]    sq_rad  [SQ_N+1];
  logic [REM_W-1:0]    sq_rem  [SQ_N+1];
  logic [ROOT_W-1:0]   sq_root [SQ_N+1];
  logic [2:0][M_W-1:0] sq_m    [SQ_N+1];
  tag_t                sq_tag  [SQ_N+1];
  logic [SUM_W-1:0]    sum;

  assign sum = SUM_W'(s4_sq[0]) + SUM_W'(s4_sq[1]) + SUM_W'(s4_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= s4_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad[0]  <= {sum, {FRAC_SH{1'b0}}};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_m[0]    <= s4_m;
      sq_tag[0]  <= s4_tag;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {sq_rem[k], sq_rad[k][RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({sq_root[k], 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (en) sq_vld[k+1] <= sq_vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad[k+1]  <= sq_rad[k] << 2;
        sq_rem[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], ge};
        sq_m[k+1]    <= sq_m[k];
        sq_tag[k+1]  <= sq_tag[k];
      end
    end
  end

  // three restoring dividers sharing the root, one quotient bit per stage
  logic                 dv_vld  [DV_N];
  logic [ROOT_W-1:0]    dv_s    [DV_N];
  logic [2:0][DR_W-1:0] dv_rem  [DV_N];
  logic [2:0][Q_W-1:0]  dv_q    [DV_N];
  tag_t                 dv_tag  [DV_N];

  for (genvar k = 0; k < DV_N; k++) begin : g_div
    logic                 vld_i;
    logic [ROOT_W-1:0]    s_i;
    logic [2:0][DR_W-1:0] rem_i;
    logic [2:0][Q_W-1:0]  q_i;
    tag_t                 tag_i;
    logic [2:0][DR_W-1:0] rem_o;
    logic [2:0][Q_W-1:0]  q_o;
    logic [DR_W-1:0]      t;

    if (k == 0) begin : g_first
      always_comb begin
        vld_i = sq_vld[SQ_N];
        s_i   = sq_root[SQ_N];
        tag_i = sq_tag[SQ_N];
        for (int i = 0; i < 3; i++) begin
          rem_i[i] = DR_W'({sq_m[SQ_N][i], 5'b00000});
          q_i[i]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_i = dv_vld[k-1];
        s_i   = dv_s[k-1];
        tag_i = dv_tag[k-1];
        rem_i = dv_rem[k-1];
        q_i   = dv_q[k-1];
      end
    end

    always_comb begin
      t = '0;
      for (int i = 0; i < 3; i++) begin
        t = rem_i[i] << 1;
        if (t >= DR_W'(s_i)) begin
          rem_o[i] = t - DR_W'(s_i);
          q_o[i]   = {q_i[i][Q_W-2:0], 1'b1};
        end else begin
          rem_o[i] = t;
          q_o[i]   = {q_i[i][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k] <= 1'b0;
      else if (en) dv_vld[k] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[k]   <= s_i;
        dv_rem[k] <= rem_o;
        dv_q[k]   <= q_o;
        dv_tag[k] <= tag_i;
      end
    end
  end

  // output stage: restore signs, zero vector gives zero
  logic [2:0][NORM_W-1:0] n_fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_tag[DV_N-1].zero) n_fin[i] = '0;
      else if (dv_tag[DV_N-1].neg[i]) n_fin[i] = ~NORM_W'(dv_q[DV_N-1][i]) + NORM_W'(1);
      else n_fin[i] = NORM_W'(dv_q[DV_N-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= dv_vld[DV_N-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec  <= n_fin;
      out_zero <= dv_tag[DV_N-1].zero;
      out_side <= dv_tag[DV_N-1].side;
    end
  end

endmodule

### rtl/core/lav_cross.sv
// two-stage cross product a x b of signed vectors, with a sideband carried along
// depends on lav_pkg
module lav_cross import lav_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [2:0][AW-1:0]    a,
  input  logic [2:0][BW-1:0]    b,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic [2:0][AW+BW:0]   out_vec,
  output logic [SW-1:0]         out_side
);

  localparam int PW = AW + BW;
  localparam int CW = PW + 1;

  // stage 1: six products
  logic                  p_vld;
  logic signed [PW-1:0]  p [6];
  logic [SW-1:0]         p_side;

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (en) p_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]   <= $signed(a[1]) * $signed(b[2]);
      p[1]   <= $signed(a[2]) * $signed(b[1]);
      p[2]   <= $signed(a[2]) * $signed(b[0]);
      p[3]   <= $signed(a[0]) * $signed(b[2]);
      p[4]   <= $signed(a[0]) * $signed(b[1]);
      p[5]   <= $signed(a[1]) * $signed(b[0]);
      p_side <= in_side;
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= p_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec[0] <= CW'(p[0]) - CW'(p[1]);
      out_vec[1] <= CW'(p[2]) - CW'(p[3]);
      out_vec[2] <= CW'(p[4]) - CW'(p[5]);
      out_side   <= p_side;
    end
  end

endmodule

### rtl/core/lav_rows.sv
// output serializer: holds one finished matrix and sends it as four row beats
// depends on lav_pkg and assert_macros.svh
module lav_rows import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     mat_vld,
  input  mat_t     mat,
  output logic     mat_rdy,
  output logic     row_valid,
  input  logic     row_ready,
  output row_out_t row
);

  mat_t       hold;
  logic [1:0] cnt;
  logic       beat;
  logic       take;

  assign beat    = row_valid && row_ready;
  assign mat_rdy = !row_valid || (row_ready && cnt == ROW_LAST);
  assign take    = mat_vld && mat_rdy;

  // row counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      cnt       <= ROW_U;
    end else if (take) begin
      row_valid <= 1'b1;
      cnt       <= ROW_U;
    end else if (beat) begin
      if (cnt == ROW_LAST) row_valid <= 1'b0;
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) hold <= mat;
  end

  // row select
  always_comb begin
    row.row_index  = cnt;
    row.degenerate = hold.degenerate;
    row.last_row   = (cnt == ROW_LAST);
    unique case (cnt)
      ROW_U, ROW_V, ROW_N: begin
        row.col0 = hold.ent[cnt][0];
        row.col1 = hold.ent[cnt][1];
        row.col2 = hold.ent[cnt][2];
        row.col3 = hold.ent[cnt][3];
      end
      default: begin
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = ONE_OUT;
      end
    endcase
  end

  `include "assert_macros.svh"

  `LAV_ASSERT_NEXT(a_row_step, beat && cnt != ROW_LAST, row_valid && cnt == $past(cnt) + 2'd1, "row beats out of order")
  `LAV_ASSERT_NOW(a_take_slot, take && row_valid, beat && cnt == ROW_LAST, "new matrix taken mid-sequence")
  `LAV_ASSERT_NEXT(a_drain, beat && cnt == ROW_LAST && !mat_vld, !row_valid, "rows continue after last beat")

endmodule

### rtl/core/look_at_view_matrix.sv
// Camera view-matrix generator. Each beat on the cam channel (eye, target and up vector,
// signed q8.8) produces four beats on the row channel: rows u, v, n of the rotation with the
// translation -(R.eye) in col3, then 0 0 0 1.0, all signed q16.16 and saturated; degenerate
// flags a zero-length forward or side vector. The datapath is a fully pipelined chain
// (difference, normalizer, cross product, normalizer, cross product, dot products) of 116
// register stages ahead of the row serializer; each normalizer holds a 31-stage square root
// and a 17-stage divider. The datapath can take a camera beat every cycle while it is not
// held; sustained throughput is limited by the single row port, which sends four row beats
// per camera, and a stalled row port holds the whole pipeline without loss.
module look_at_view_matrix import lav_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cam_valid,
  output logic     cam_ready,
  input  cam_in_t  cam,
  output logic     row_valid,
  input  logic     row_ready,
  output row_out_t row
);

  localparam int DW  = COORD_W + 1;
  localparam int NW  = NORM_W;
  localparam int C1W = COORD_W + NW + 1;
  localparam int C2W = 2 * NW + 1;
  localparam int PW  = ENT_W + COORD_W;
  localparam int DTW = PW + 2;
  localparam int GW  = (DTW > OUT_W) ? DTW : OUT_W;
  localparam int SW1 = 6 * COORD_W;
  localparam int SWX = 3 * COORD_W + 3 * NW + 1;
  localparam int SW2 = 3 * COORD_W + 6 * NW + 1;
  localparam int V_SH = 16;
  localparam int T_SH = 8;

  localparam logic signed [GW-1:0] SAT_HI = {{(GW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [GW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [GW-1:0] x);
    logic [OUT_W-1:0] r;
    if (x > SAT_HI) r = OUT_W'(SAT_HI);
    else if (x < SAT_LO) r = OUT_W'(SAT_LO);
    else r = OUT_W'(x);
    return r;
  endfunction

  logic adv;
  logic mat_vld;
  logic mat_rdy;
  mat_t mat;

  // whole pipeline moves when its last stage can drain
  assign adv       = !mat_vld || mat_rdy;
  assign cam_ready = adv;

  // forward difference
  logic [2:0][COORD_W-1:0] eye_in, tgt_in, up_in;
  logic                    d_vld;
  logic [2:0][DW-1:0]      d_vec;
  logic [2:0][COORD_W-1:0] d_eye, d_up;

  assign eye_in = {cam.eye_z, cam.eye_y, cam.eye_x};
  assign tgt_in = {cam.target_z, cam.target_y, cam.target_x};
  assign up_in  = {cam.upward_z, cam.upward_y, cam.upward_x};

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (adv) d_vld <= cam_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_vec[i] <= DW'($signed(eye_in[i])) - DW'($signed(tgt_in[i]));
      end
      d_eye <= eye_in;
      d_up  <= up_in;
    end
  end

  // n = normalize(eye - target)
  logic                    n1_vld, n1_zero;
  logic [2:0][NW-1:0]      n1_vec;
  logic [SW1-1:0]          n1_side;
  logic [2:0][COORD_W-1:0] n1_eye, n1_up;

  lav_norm #(.IW(DW), .SW(SW1)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(d_vld), .in_vec(d_vec), .in_side({d_eye, d_up}),
    .out_vld(n1_vld), .out_vec(n1_vec), .out_zero(n1_zero), .out_side(n1_side)
  );

  assign {n1_eye, n1_up} = n1_side;

  // up x n
  logic                x1_vld;
  logic [2:0][C1W-1:0] x1_vec;
  logic [SWX-1:0]      x1_side;

  lav_cross #(.AW(COORD_W), .BW(NW), .SW(SWX)) u_cross_side (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(n1_vld), .a(n1_up), .b(n1_vec), .in_side({n1_eye, n1_vec, n1_zero}),
    .out_vld(x1_vld), .out_vec(x1_vec), .out_side(x1_side)
  );

  // u = normalize(up x n)
  logic                    n2_vld, n2_zero, n2_z1;
  logic [2:0][NW-1:0]      n2_vec, n2_n;
  logic [SWX-1:0]          n2_side;
  logic [2:0][COORD_W-1:0] n2_eye;

  lav_norm #(.IW(C1W), .SW(SWX)) u_norm_side (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(x1_vld), .in_vec(x1_vec), .in_side(x1_side),
    .out_vld(n2_vld), .out_vec(n2_vec), .out_zero(n2_zero), .out_side(n2_side)
  );

  assign {n2_eye, n2_n, n2_z1} = n2_side;

  // n x u
  logic                    x2_vld, x2_deg;
  logic [2:0][C2W-1:0]     x2_vec;
  logic [SW2-1:0]          x2_side;
  logic [2:0][COORD_W-1:0] x2_eye;
  logic [2:0][NW-1:0]      x2_n, x2_u;

  lav_cross #(.AW(NW), .BW(NW), .SW(SW2)) u_cross_up (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(n2_vld), .a(n2_n), .b(n2_vec),
    .in_side({n2_eye, n2_n, n2_vec, n2_z1 | n2_zero}),
    .out_vld(x2_vld), .out_vec(x2_vec), .out_side(x2_side)
  );

  assign {x2_eye, x2_n, x2_u, x2_deg} = x2_side;

  // rotation rows, v truncated toward zero to q16.16
  logic                    vs_vld, vs_deg;
  logic [2:0][2:0][ENT_W-1:0] vs_ent;
  logic [2:0][COORD_W-1:0] vs_eye;
  logic [2:0][ENT_W-1:0]   v_tr;
  logic [C2W-1:0]          v_mag, v_sh;

  always_comb begin
    v_mag = '0;
    v_sh  = '0;
    for (int i = 0; i < 3; i++) begin
      v_mag = x2_vec[i][C2W-1] ? (~x2_vec[i] + C2W'(1)) : x2_vec[i];
      v_sh  = v_mag >> V_SH;
      v_tr[i] = x2_vec[i][C2W-1] ? ENT_W'(~v_sh + C2W'(1)) : ENT_W'(v_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vs_vld <= 1'b0;
    else if (adv) vs_vld <= x2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        vs_ent[0][j] <= ENT_W'($signed(x2_u[j]));
        vs_ent[1][j] <= v_tr[j];
        vs_ent[2][j] <= ENT_W'($signed(x2_n[j]));
      end
      vs_eye <= x2_eye;
      vs_deg <= x2_deg;
    end
  end

  // products for the translation column
  logic                       ps_vld, ps_deg;
  logic [2:0][2:0][PW-1:0]    ps_prod;
  logic [2:0][2:0][ENT_W-1:0] ps_ent;

  always_ff @(posedge clk) begin
    if (rst) ps_vld <= 1'b0;
    else if (adv) ps_vld <= vs_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          ps_prod[r][j] <= PW'($signed(vs_ent[r][j]) * $signed(vs_eye[j]));
        end
      end
      ps_ent <= vs_ent;
      ps_deg <= vs_deg;
    end
  end

  // dot sums, -(dot) truncated toward zero to q16.16, saturation
  logic [2:0][DTW-1:0] dot, t_col;
  logic [DTW-1:0]      t_mag, t_sh;
  mat_t                mat_next;

  always_comb begin
    t_mag = '0;
    t_sh  = '0;
    mat_next.degenerate = ps_deg;
    for (int r = 0; r < 3; r++) begin
      dot[r] = DTW'($signed(ps_prod[r][0])) + DTW'($signed(ps_prod[r][1]))
             + DTW'($signed(ps_prod[r][2]));
      t_mag = dot[r][DTW-1] ? (~dot[r] + DTW'(1)) : dot[r];
      t_sh  = t_mag >> T_SH;
      t_col[r] = dot[r][DTW-1] ? t_sh : (~t_sh + DTW'(1));
      for (int j = 0; j < 3; j++) begin
        mat_next.ent[r][j] = sat_out(GW'($signed(ps_ent[r][j])));
      end
      mat_next.ent[r][3] = sat_out(GW'($signed(t_col[r])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mat_vld <= 1'b0;
    else if (adv) mat_vld <= ps_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) mat <= mat_next;
  end

  lav_rows u_rows (
    .clk(clk), .rst(rst),
    .mat_vld(mat_vld), .mat(mat), .mat_rdy(mat_rdy),
    .row_valid(row_valid), .row_ready(row_ready), .row(row)
  );

endmodule
